[rtl/arc_handle_correction_factor_assert.svh]
// assertion macros for the arc handle correction factor block
// used by the top level only, no other dependencies
`ifndef ARC_HANDLE_CORRECTION_FACTOR_ASSERT_SVH
`define ARC_HANDLE_CORRECTION_FACTOR_ASSERT_SVH
// implication check on every clock, off while reset is held
`define ACHF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("achf check failed");
// next cycle implication check
`define ACHF_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("achf check failed");
`endif

[rtl/achf_pkg.sv]
// constants, pipeline word type and tanh table functions for the correction factor
// no dependencies
package achf_pkg;
   localparam int TanhEntriesDefault = 256;
   localparam logic [15:0] WinvQ16   = 16'd51258;
   localparam logic [17:0] K2AbsQ16  = 18'd135853;
   localparam logic [17:0] K3AbsQ16  = 18'd90569;
   localparam logic [17:0] ThreeQ16  = 18'd196608;
   localparam logic [17:0] TwoQ16    = 18'd131072;
   localparam logic [15:0] OneQ14    = 16'd16384;
   localparam logic [16:0] OneQ16    = 17'd65536;
   localparam longint unsigned OneQ30 = 64'd1 << 30;

   // restoring shift-subtract quotient, elaboration only
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^(-f) in Q30, taylor series, elaboration only
   function automatic longint unsigned exp_neg_q30(input longint unsigned f);
      longint sum;
      longint unsigned term;
      sum  = longint'(OneQ30);
      term = OneQ30;
      for (int n = 1; n <= 20; n++) begin
         term = udiv((term * f) >> 30, longint'(n));
         if (n[0]) sum = sum - longint'(term);
         else      sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      return longint'(sum);
   endfunction

   // tanh(8*i/entries) in Q16, elaboration only
   function automatic logic [16:0] tanh_point(input int idx, input int entries);
      longint unsigned e1, u, k, r, f, e, num, den;
      if (idx >= entries) return OneQ16;
      e1 = exp_neg_q30(OneQ30);
      u  = 64'd16 * longint'(idx);
      k  = udiv(u, longint'(entries));
      r  = u - k * longint'(entries);
      f  = udiv(r << 30, longint'(entries));
      e  = exp_neg_q30(f);
      for (longint unsigned j = 0; j < k; j++)
         e = (e * e1 + (64'd1 << 29)) >> 30;
      if (e > OneQ30) e = OneQ30;
      num = OneQ30 - e;
      den = OneQ30 + e;
      return 17'(udiv(num * 64'd65536 + (den >> 1), den));
   endfunction

   // one pipeline word, fields filled in as the stages go
   typedef struct packed {
      logic        eq;
      logic        az;
      logic        dneg;
      logic        aneg;
      logic        sat;
      logic        neg;
      logic        big;
      logic [36:0] rem;
      logic [19:0] den;
      logic [15:0] q;
      logic [28:0] p;
      logic [34:0] m0;
      logic [34:0] m1;
      logic [16:0] xmag;
      logic [16:0] x2;
      logic [16:0] x3;
      logic [34:0] t2;
      logic [34:0] t3;
   } pipe_type;
endpackage

[rtl/achf_if.sv]
// handshake channels of the correction factor block: angle pair in, factor out
// no dependencies
interface achf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] half_angle;
   logic signed [15:0] other_angle;
   modport source (output valid, half_angle, other_angle, input ready);
   modport sink   (input valid, half_angle, other_angle, output ready);
endinterface

interface achf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] correction_factor;
   modport source (output valid, correction_factor, input ready);
   modport sink   (input valid, correction_factor, output ready);
endinterface

[rtl/arc_handle_correction_factor.sv]
// top level: pipelined arc handle correction factor
// depends on achf_pkg, achf_if and arc_handle_correction_factor_assert.svh
// One angle pair enters per cycle while the result side does not stall; it
// then passes through the 16-stage restoring divider that forms the relative
// angle, followed by table interpolation and the cubic multiplies. A stall on
// the result side freezes the whole pipeline, so words are neither lost nor
// repeated. The tanh table is a constant built at elaboration.
`include "arc_handle_correction_factor_assert.svh"
module arc_handle_correction_factor
   import achf_pkg::*;
#(
   parameter int TANH_ENTRIES = TanhEntriesDefault
) (
   input  logic clock,
   input  logic reset,
   achf_req_if.sink   req,
   achf_rsp_if.source rsp
);
   localparam int NumStages = 25;
   localparam int IdxW      = $clog2(TANH_ENTRIES + 1);
   localparam int DivFirst  = 2;
   localparam int DivLast   = 17;

   logic [16:0] tab [TANH_ENTRIES + 1];
   pipe_type st_ff [NumStages];
   pipe_type st_in [NumStages];
   logic [NumStages-1:0] v_ff;
   logic adv;
   logic [15:0] result;

   // constant tanh table
   for (genvar g = 0; g <= TANH_ENTRIES; g++) begin : g_tab
      assign tab[g] = tanh_point(g, TANH_ENTRIES);
   end

   // global advance
   assign adv       = !v_ff[NumStages-1] || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = v_ff[NumStages-1];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NumStages-2:0], req.valid};
      end
   end

   for (genvar s = 0; s < NumStages; s++) begin : g_st
      // stage registers
      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[s] <= st_in[s];
         end
      end

      if (s == 0) begin : g_entry
         // difference, magnitudes and dividend
         logic signed [16:0] d;
         logic [16:0] dm;
         logic [15:0] am;
         always_comb begin
            d  = 17'(req.other_angle) - 17'(req.half_angle);
            dm = d[16] ? 17'(-d) : 17'(d);
            am = req.half_angle[15] ? 16'(-req.half_angle) : 16'(req.half_angle);
            st_in[s]      = '0;
            st_in[s].eq   = (req.half_angle == req.other_angle);
            st_in[s].az   = (req.half_angle == 16'sd0);
            st_in[s].dneg = d[16];
            st_in[s].aneg = req.half_angle[15];
            st_in[s].rem  = 37'(WinvQ16 * dm) + 37'({am, 3'b000});
            st_in[s].den  = {am, 4'b0000};
         end
      end else if (s == 1) begin : g_satchk
         // quotient of 16.0 or more saturates
         always_comb begin
            st_in[s]     = st_ff[s-1];
            st_in[s].sat = (st_ff[s-1].rem >= {1'b0, st_ff[s-1].den, 16'd0});
         end
      end else if (s >= DivFirst && s <= DivLast) begin : g_div
         // one quotient bit per stage
         localparam int Bit = DivLast - s;
         logic [36:0] dsh;
         always_comb begin
            dsh      = 37'(st_ff[s-1].den) << Bit;
            st_in[s] = st_ff[s-1];
            if (st_ff[s-1].rem >= dsh) begin
               st_in[s].rem  = st_ff[s-1].rem - dsh;
               st_in[s].q[Bit] = 1'b1;
            end
         end
      end else if (s == 18) begin : g_pos
         // sign of x and table position
         always_comb begin
            st_in[s]     = st_ff[s-1];
            st_in[s].neg = st_ff[s-1].az ? st_ff[s-1].dneg :
                           ((st_ff[s-1].dneg != st_ff[s-1].aneg) && (st_ff[s-1].q != 16'd0));
            st_in[s].big = st_ff[s-1].az || st_ff[s-1].sat;
            st_in[s].p   = 29'(st_ff[s-1].q * 29'(TANH_ENTRIES));
         end
      end else if (s == 19) begin : g_interp
         // table read and weight products
         logic [IdxW-1:0] idx;
         logic [15:0] f;
         always_comb begin
            idx         = IdxW'(st_ff[s-1].p >> 16);
            f           = st_ff[s-1].p[15:0];
            st_in[s]    = st_ff[s-1];
            st_in[s].m0 = 35'(tab[idx] * (OneQ16 - 17'(f)));
            st_in[s].m1 = 35'(tab[idx + IdxW'(1)] * f);
         end
      end else if (s == 20) begin : g_xmag
         // interpolated magnitude of x
         logic [34:0] sum;
         always_comb begin
            sum           = st_ff[s-1].m0 + st_ff[s-1].m1 + 35'd32768;
            st_in[s]      = st_ff[s-1];
            st_in[s].xmag = st_ff[s-1].big ? OneQ16 : sum[32:16];
         end
      end else if (s == 21) begin : g_x2
         logic [33:0] sq;
         always_comb begin
            sq          = st_ff[s-1].xmag * st_ff[s-1].xmag + 34'd32768;
            st_in[s]    = st_ff[s-1];
            st_in[s].x2 = sq[32:16];
         end
      end else if (s == 22) begin : g_x3
         logic [33:0] cu;
         always_comb begin
            cu          = st_ff[s-1].x2 * st_ff[s-1].xmag + 34'd32768;
            st_in[s]    = st_ff[s-1];
            st_in[s].x3 = cu[32:16];
         end
      end else if (s == 23) begin : g_terms
         // coefficient products
         always_comb begin
            st_in[s]    = st_ff[s-1];
            st_in[s].t2 = 35'((st_ff[s-1].neg ? K2AbsQ16 : ThreeQ16) * st_ff[s-1].x2);
            st_in[s].t3 = 35'((st_ff[s-1].neg ? K3AbsQ16 : TwoQ16) * st_ff[s-1].x3);
         end
      end else begin : g_pass
         always_comb begin
            st_in[s] = st_ff[s-1];
         end
      end
   end

   // cubic sum, rounding and clamp on the last stage
   logic signed [37:0] r;
   logic [37:0] rr;
   always_comb begin
      if (st_ff[NumStages-1].neg)
         r = (38'sd1 <<< 32) - 38'(st_ff[NumStages-1].t2) + 38'(st_ff[NumStages-1].t3);
      else
         r = (38'sd1 <<< 32) + 38'(st_ff[NumStages-1].t2) - 38'(st_ff[NumStages-1].t3);
      rr = r[37] ? 38'd0 : ((38'(r) + 38'd131072) >> 18);
      if (st_ff[NumStages-1].eq)     result = OneQ14;
      else if (rr > 38'd65535)       result = 16'hFFFF;
      else                           result = rr[15:0];
   end
   assign rsp.correction_factor = result;

   // checks
   `ACHF_ASSERT_IMP(a_eq_one, v_ff[NumStages-1] && st_ff[NumStages-1].eq, result == OneQ14)
   `ACHF_ASSERT_IMP(a_rem_lt_den, v_ff[DivLast] && !st_ff[DivLast].az && !st_ff[DivLast].sat, st_ff[DivLast].rem < 37'(st_ff[DivLast].den))
   `ACHF_ASSERT_IMP(a_xmag_range, v_ff[20], st_ff[20].xmag <= OneQ16)
   `ACHF_ASSERT_NXT(a_stall_hold, rsp.valid && !rsp.ready, rsp.valid)
endmodule
